[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define DPM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define DPM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/dpm_pkg.sv]
`default_nettype none

package dpm_pkg;

    localparam int ALPHABET = 4;
    localparam int SYM_W = 2;
    localparam int COUNT_W = 20;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 20'hFFFFF;

    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    typedef logic [SYM_W-1:0] sym_t;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_BUILD  = 2'd1,
        REQ_SCAN   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLR,
        ST_I_RD,
        ST_I_WR,
        ST_I_NEW,
        ST_S_START,
        ST_ADV_CHK,
        ST_ADV_TM,
        ST_B_ROOT,
        ST_B_RLD,
        ST_B_RCH,
        ST_B_POP,
        ST_B_NOW,
        ST_B_NLD,
        ST_B_CH,
        ST_FIN
    } st_t;

    function automatic sym_t sym_of(input logic [7:0] c);
        sym_t s;
        priority if (c == CHAR_A)
            s = 2'd0;
        else if (c == CHAR_G)
            s = 2'd1;
        else if (c == CHAR_T)
            s = 2'd2;
        else
            s = 2'd3;
        return s;
    endfunction

endpackage

`default_nettype wire

[hdl/dpm_req_if.sv]
`default_nettype none

interface dpm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] char_code;
    logic       last;

    modport source (output valid, output req_type, output char_code, output last,
                    input ready);
    modport sink (input valid, input req_type, input char_code, input last,
                  output ready);
endinterface

`default_nettype wire

[hdl/dpm_rsp_if.sv]
`default_nettype none

interface dpm_rsp_if;
    logic        valid;
    logic        ready;
    logic        hit;
    logic [19:0] match_total;
    logic        text_done;
    logic        status;

    modport source (output valid, output hit, output match_total, output text_done,
                    output status, input ready);
    modport sink (input valid, input hit, input match_total, input text_done,
                  input status, output ready);
endinterface

`default_nettype wire

[hdl/dpm_ram.sv]
`default_nettype none

module dpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/dna_multi_pattern_matcher_top.sv]
// Aho-Corasick matcher over the symbols A, G, T and "other".
// Channel req (sink) carries one request: req_type, char_code, last.
// Channel rsp (source) returns exactly one response per request, in order.
// Insert: follows the edge or allocates a new node; the node table holds
// MAX_NODES nodes and a full table drops the character with status set.
// Scan: follows failure links until an edge or the root is found; goto, failure and
// terminal tables sit in simple dual-port synchronous RAMs, one read each per cycle.
// Build: breadth-first walk through a queue RAM; failure links are followed for
// each child of a dequeued node, and no request is taken meanwhile.
// Clear: rewrites only the root; nodes are re-zeroed on allocation.
// The next request is taken in the cycle after its predecessor's response is loaded.
// After reset the block initializes the root in ST_INIT, then idles.
// Requests are taken one at a time; a new request is accepted while the
// previous response still waits in the output register. If rsp stalls, the
// finished response of the next request holds until the register frees.
`default_nettype none

module dna_multi_pattern_matcher_top
    import dpm_pkg::*;
#(
    parameter int MAX_NODES = 4096
) (
    input wire logic clk,
    input wire logic rst_n,
    dpm_req_if.sink  req,
    dpm_rsp_if.source rsp
);

`include "assert_macros.svh"

    localparam int NW = $clog2(MAX_NODES);
    localparam int RW = ALPHABET * NW;
    localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

    st_t               st_reg, st_next;
    req_t              rq_reg, rq_next;
    sym_t              sym_reg, sym_next;
    logic              last_reg, last_next;
    logic [NW-1:0]     insert_node_reg, insert_node_next;
    logic [NW-1:0]     scan_node_reg, scan_node_next;
    logic [NW-1:0]     nodes_used_reg, nodes_used_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [NW-1:0]     adv_p_reg, adv_p_next;
    sym_t              adv_sym_reg, adv_sym_next;
    logic [NW-1:0]     nxt_reg, nxt_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [NW-1:0]     failnow_reg, failnow_next;
    logic [NW-1:0]     head_reg, head_next;
    logic [NW-1:0]     tail_reg, tail_next;
    sym_t              s_reg, s_next;
    logic              res_hit_reg, res_hit_next;
    logic [COUNT_W-1:0] res_total_reg, res_total_next;
    logic              res_done_reg, res_done_next;
    logic              res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg, out_hit_next;
    logic [COUNT_W-1:0] out_total_reg, out_total_next;
    logic              out_done_reg, out_done_next;
    logic              out_status_reg, out_status_next;

    logic              g_we, g_re, f_we, f_re, t_we, t_re, t_wdata, t_rdata, q_we, q_re;
    logic [NW-1:0]     g_waddr, g_raddr, f_waddr, f_raddr, f_wdata, f_rdata;
    logic [NW-1:0]     t_waddr, t_raddr, q_waddr, q_raddr, q_wdata, q_rdata;
    logic [RW-1:0]     g_wdata, g_rdata;

    logic              req_fire, out_room, ins_new, adv_fall, t_hit;
    logic [NW-1:0]     ins_edge, adv_edge, row_child;
    logic [COUNT_W-1:0] count_inc;

    dpm_ram #(.WIDTH(RW), .DEPTH(MAX_NODES)) u_goto (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .re(g_re), .raddr(g_raddr), .rdata(g_rdata)
    );
    dpm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
        .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
        .re(f_re), .raddr(f_raddr), .rdata(f_rdata)
    );
    dpm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_term (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .re(t_re), .raddr(t_raddr), .rdata(t_rdata)
    );
    dpm_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
    );

    assign req.ready = (st_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_room  = !out_valid_reg || rsp.ready;

    assign ins_edge  = g_rdata[sym_reg * NW +: NW];
    assign adv_edge  = g_rdata[adv_sym_reg * NW +: NW];
    assign row_child = row_reg[s_reg * NW +: NW];
    assign ins_new   = (ins_edge == '0) && (nodes_used_reg != LAST_NODE);
    assign adv_fall  = (adv_p_reg != '0) && (adv_edge == '0);
    assign t_hit     = t_rdata;
    assign count_inc = count_reg + COUNT_W'(t_hit && (count_reg != COUNT_MAX));

    assign rsp.valid       = out_valid_reg;
    assign rsp.hit         = out_hit_reg;
    assign rsp.match_total = out_total_reg;
    assign rsp.text_done   = out_done_reg;
    assign rsp.status      = out_status_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_INIT:    st_next = ST_IDLE;
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req_t'(req.req_type))
                        REQ_INSERT: st_next = ST_I_RD;
                        REQ_BUILD:  st_next = ST_B_ROOT;
                        REQ_SCAN:   st_next = ST_S_START;
                        REQ_CLEAR:  st_next = ST_CLR;
                        default:    st_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLR:     st_next = ST_FIN;
            ST_I_RD:    st_next = ST_I_WR;
            ST_I_WR:    st_next = ins_new ? ST_I_NEW : ST_FIN;
            ST_I_NEW:   st_next = ST_FIN;
            ST_S_START: st_next = ST_ADV_CHK;
            ST_ADV_CHK: st_next = adv_fall ? ST_ADV_CHK : ST_ADV_TM;
            ST_ADV_TM:
            begin
                if (rq_reg == REQ_SCAN)
                    st_next = ST_FIN;
                else
                    st_next = (s_reg == sym_t'(ALPHABET - 1)) ? ST_B_POP : ST_B_CH;
            end
            ST_B_ROOT:  st_next = ST_B_RLD;
            ST_B_RLD:   st_next = ST_B_RCH;
            ST_B_RCH:   st_next = (s_reg == sym_t'(ALPHABET - 1)) ? ST_B_POP : ST_B_RCH;
            ST_B_POP:   st_next = (head_reg == tail_reg) ? ST_FIN : ST_B_NOW;
            ST_B_NOW:   st_next = ST_B_NLD;
            ST_B_NLD:   st_next = ST_B_CH;
            ST_B_CH:
            begin
                if (row_child != '0)
                    st_next = ST_ADV_CHK;
                else
                    st_next = (s_reg == sym_t'(ALPHABET - 1)) ? ST_B_POP : ST_B_CH;
            end
            ST_FIN:     st_next = out_room ? ST_IDLE : ST_FIN;
            default:    st_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        rq_next          = rq_reg;
        sym_next         = sym_reg;
        last_next        = last_reg;
        insert_node_next = insert_node_reg;
        scan_node_next   = scan_node_reg;
        nodes_used_next  = nodes_used_reg;
        count_next       = count_reg;
        adv_p_next       = adv_p_reg;
        adv_sym_next     = adv_sym_reg;
        nxt_next         = nxt_reg;
        row_next         = row_reg;
        failnow_next     = failnow_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        s_next           = s_reg;
        res_hit_next     = res_hit_reg;
        res_total_next   = res_total_reg;
        res_done_next    = res_done_reg;
        res_status_next  = res_status_reg;
        g_we = 1'b0; g_waddr = '0; g_wdata = '0; g_re = 1'b0; g_raddr = '0;
        f_we = 1'b0; f_waddr = '0; f_wdata = '0; f_re = 1'b0; f_raddr = '0;
        t_we = 1'b0; t_waddr = '0; t_wdata = 1'b0; t_re = 1'b0; t_raddr = '0;
        q_we = 1'b0; q_waddr = '0; q_wdata = '0; q_re = 1'b0; q_raddr = '0;

        unique case (st_reg)
            ST_INIT, ST_CLR:
            begin
                g_we = 1'b1;
                f_we = 1'b1;
                t_we = 1'b1;
                nodes_used_next  = '0;
                insert_node_next = '0;
                scan_node_next   = '0;
                count_next       = '0;
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    rq_next         = req_t'(req.req_type);
                    sym_next        = sym_of(req.char_code);
                    last_next       = req.last;
                    res_hit_next    = 1'b0;
                    res_total_next  = '0;
                    res_done_next   = 1'b0;
                    res_status_next = 1'b0;
                end
            end
            ST_I_RD:
            begin
                g_re    = 1'b1;
                g_raddr = insert_node_reg;
            end
            ST_I_WR:
            begin
                if (ins_edge != '0)
                begin
                    t_we    = last_reg;
                    t_waddr = ins_edge;
                    t_wdata = 1'b1;
                    insert_node_next = last_reg ? '0 : ins_edge;
                end
                else if (!ins_new)
                begin
                    res_status_next = 1'b1;
                    if (last_reg)
                        insert_node_next = '0;
                end
                else
                begin
                    nodes_used_next = nodes_used_reg + NW'(1);
                    nxt_next        = nodes_used_reg + NW'(1);
                    g_we    = 1'b1;
                    g_waddr = insert_node_reg;
                    g_wdata = g_rdata;
                    g_wdata[sym_reg * NW +: NW] = nodes_used_reg + NW'(1);
                    f_we    = 1'b1;
                    f_waddr = nodes_used_reg + NW'(1);
                    t_we    = 1'b1;
                    t_waddr = nodes_used_reg + NW'(1);
                    t_wdata = last_reg;
                    insert_node_next = last_reg ? '0 : nodes_used_reg + NW'(1);
                end
            end
            ST_I_NEW:
            begin
                g_we    = 1'b1;
                g_waddr = nxt_reg;
            end
            ST_S_START:
            begin
                g_re = 1'b1; g_raddr = scan_node_reg;
                f_re = 1'b1; f_raddr = scan_node_reg;
                adv_p_next   = scan_node_reg;
                adv_sym_next = sym_reg;
            end
            ST_ADV_CHK:
            begin
                if (adv_fall)
                begin
                    adv_p_next = f_rdata;
                    g_re = 1'b1; g_raddr = f_rdata;
                    f_re = 1'b1; f_raddr = f_rdata;
                end
                else
                begin
                    adv_p_next = adv_edge;
                    t_re    = 1'b1;
                    t_raddr = adv_edge;
                end
            end
            ST_ADV_TM:
            begin
                if (rq_reg == REQ_SCAN)
                begin
                    res_hit_next   = t_hit;
                    res_total_next = count_inc;
                    res_done_next  = last_reg;
                    scan_node_next = last_reg ? '0 : adv_p_reg;
                    count_next     = last_reg ? '0 : count_inc;
                end
                else
                begin
                    f_we = 1'b1; f_waddr = nxt_reg; f_wdata = adv_p_reg;
                    t_we = t_hit; t_waddr = nxt_reg; t_wdata = 1'b1;
                    q_we = 1'b1; q_waddr = tail_reg; q_wdata = nxt_reg;
                    tail_next = tail_reg + NW'(1);
                    s_next    = s_reg + sym_t'(1);
                end
            end
            ST_B_ROOT:
            begin
                g_re = 1'b1;
                f_we = 1'b1;
                head_next = '0;
                tail_next = '0;
            end
            ST_B_RLD:
            begin
                row_next = g_rdata;
                s_next   = '0;
            end
            ST_B_RCH:
            begin
                if (row_child != '0)
                begin
                    f_we = 1'b1; f_waddr = row_child;
                    q_we = 1'b1; q_waddr = tail_reg; q_wdata = row_child;
                    tail_next = tail_reg + NW'(1);
                end
                s_next = s_reg + sym_t'(1);
            end
            ST_B_POP:
            begin
                if (head_reg != tail_reg)
                begin
                    q_re    = 1'b1;
                    q_raddr = head_reg;
                    head_next = head_reg + NW'(1);
                end
            end
            ST_B_NOW:
            begin
                g_re = 1'b1; g_raddr = q_rdata;
                f_re = 1'b1; f_raddr = q_rdata;
            end
            ST_B_NLD:
            begin
                row_next     = g_rdata;
                failnow_next = f_rdata;
                s_next       = '0;
            end
            ST_B_CH:
            begin
                if (row_child != '0)
                begin
                    nxt_next     = row_child;
                    adv_p_next   = failnow_reg;
                    adv_sym_next = s_reg;
                    g_re = 1'b1; g_raddr = failnow_reg;
                    f_re = 1'b1; f_raddr = failnow_reg;
                end
                else
                begin
                    s_next = s_reg + sym_t'(1);
                end
            end
            ST_FIN:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_hit_next    = out_hit_reg;
        out_total_next  = out_total_reg;
        out_done_next   = out_done_reg;
        out_status_next = out_status_reg;
        if ((st_reg == ST_FIN) && out_room)
        begin
            out_valid_next  = 1'b1;
            out_hit_next    = res_hit_reg;
            out_total_next  = res_total_reg;
            out_done_next   = res_done_reg;
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= ST_INIT;
            insert_node_reg <= '0;
            scan_node_reg   <= '0;
            nodes_used_reg  <= '0;
            count_reg       <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            s_reg           <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            st_reg          <= st_next;
            insert_node_reg <= insert_node_next;
            scan_node_reg   <= scan_node_next;
            nodes_used_reg  <= nodes_used_next;
            count_reg       <= count_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            s_reg           <= s_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_reg         <= rq_next;
        sym_reg        <= sym_next;
        last_reg       <= last_next;
        adv_p_reg      <= adv_p_next;
        adv_sym_reg    <= adv_sym_next;
        nxt_reg        <= nxt_next;
        row_reg        <= row_next;
        failnow_reg    <= failnow_next;
        res_hit_reg    <= res_hit_next;
        res_total_reg  <= res_total_next;
        res_done_reg   <= res_done_next;
        res_status_reg <= res_status_next;
        out_hit_reg    <= out_hit_next;
        out_total_reg  <= out_total_next;
        out_done_reg   <= out_done_next;
        out_status_reg <= out_status_next;
    end

    `DPM_ASSERT_NXT(a_req_leaves_idle, req_fire, st_reg != ST_IDLE, "request did not start work")
    `DPM_ASSERT_IMP(a_queue_order, st_reg == ST_B_POP, head_reg <= tail_reg, "walk queue underrun")
    `DPM_ASSERT_IMP(a_hit_counts, rsp.valid && rsp.hit, rsp.match_total != '0, "hit without count")
    `DPM_ASSERT_IMP(a_status_alone, rsp.valid && rsp.status, !rsp.hit && !rsp.text_done,
                    "status set on a scan response")

endmodule

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
    import dpm_pkg::*;

    localparam int NODES = 64;
    localparam int ITEMS = 1600;

    typedef struct packed {
        logic        hit;
        logic [19:0] total;
        logic        done;
        logic        status;
    } match_rsp_t;

    class match_scoreboard;
        logic [11:0] goto_tbl[NODES*ALPHABET];
        logic [11:0] fail_tbl[NODES];
        logic        term_tbl[NODES];
        logic [11:0] walk_q[NODES];
        int unsigned nodes_used;
        int unsigned ins_node;
        int unsigned scan_node;
        logic [19:0] text_count;
        match_rsp_t  pending[$];
        int          errors;

        function new();
            errors = 0;
            wipe();
        endfunction

        function void wipe();
            foreach (goto_tbl[i]) goto_tbl[i] = '0;
            foreach (fail_tbl[i]) fail_tbl[i] = '0;
            foreach (term_tbl[i]) term_tbl[i] = 1'b0;
            nodes_used = 0;
            ins_node = 0;
            scan_node = 0;
            text_count = '0;
        endfunction

        function int unsigned sym_code(logic [7:0] c);
            if (c == CHAR_A) return 0;
            if (c == CHAR_G) return 1;
            if (c == CHAR_T) return 2;
            return 3;
        endfunction

        function int unsigned child_of(int unsigned n, int unsigned s);
            return goto_tbl[n*ALPHABET + s];
        endfunction

        function int unsigned follow(int unsigned n, int unsigned s);
            int unsigned p;
            int unsigned guard;
            p = n;
            guard = 0;
            while (p != 0 && child_of(p, s) == 0 && guard < NODES)
            begin
                p = fail_tbl[p];
                guard++;
            end
            if (guard >= NODES)
                p = 0;
            return child_of(p, s);
        endfunction

        function void build_links();
            int unsigned head;
            int unsigned tail;
            int unsigned c;
            int unsigned cur;
            int unsigned f;
            head = 0;
            tail = 0;
            fail_tbl[0] = '0;
            for (int s = 0; s < ALPHABET; s++)
            begin
                c = child_of(0, s);
                if (c != 0 && tail < NODES)
                begin
                    fail_tbl[c] = '0;
                    walk_q[tail++] = c;
                end
            end
            while (head < tail)
            begin
                cur = walk_q[head++];
                for (int s = 0; s < ALPHABET; s++)
                begin
                    c = child_of(cur, s);
                    if (c != 0)
                    begin
                        f = follow(fail_tbl[cur], s);
                        fail_tbl[c] = f;
                        if (term_tbl[f])
                            term_tbl[c] = 1'b1;
                        if (tail < NODES)
                            walk_q[tail++] = c;
                    end
                end
            end
        endfunction

        function void note(req_t r, logic [7:0] c, logic l);
            match_rsp_t e;
            int unsigned s;
            int unsigned nxt;
            bit dropped;
            e = '0;
            s = sym_code(c);
            case (r)
                REQ_INSERT:
                begin
                    nxt = child_of(ins_node, s);
                    dropped = 0;
                    if (nxt == 0)
                    begin
                        if (nodes_used + 1 >= NODES)
                            dropped = 1;
                        else
                        begin
                            nodes_used++;
                            nxt = nodes_used;
                            goto_tbl[ins_node*ALPHABET + s] = nxt;
                        end
                    end
                    if (dropped)
                    begin
                        e.status = 1'b1;
                        if (l)
                            ins_node = 0;
                    end
                    else if (l)
                    begin
                        term_tbl[nxt] = 1'b1;
                        ins_node = 0;
                    end
                    else
                        ins_node = nxt;
                end
                REQ_BUILD: build_links();
                REQ_SCAN:
                begin
                    scan_node = follow(scan_node, s);
                    if (term_tbl[scan_node])
                    begin
                        e.hit = 1'b1;
                        if (text_count != COUNT_MAX)
                            text_count++;
                    end
                    e.total = text_count;
                    if (l)
                    begin
                        e.done = 1'b1;
                        scan_node = 0;
                        text_count = '0;
                    end
                end
                default: wipe();
            endcase
            pending = {pending, e};
        endfunction

        function void check(match_rsp_t got);
            match_rsp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected response %p", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.hit !== e.hit)
            begin
                $display("%0t: hit expected %0d actual %0d", $time, e.hit, got.hit);
                errors++;
            end
            if (got.total !== e.total)
            begin
                $display("%0t: match_total expected %0d actual %0d", $time, e.total,
                         got.total);
                errors++;
            end
            if (got.done !== e.done)
            begin
                $display("%0t: text_done expected %0d actual %0d", $time, e.done,
                         got.done);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status,
                         got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    dpm_req_if req_bus();
    dpm_rsp_if rsp_bus();
    match_scoreboard sb;
    int burst_left;
    int sent;
    int accepted;
    int hold_cnt;
    bit held_once;
    int unsigned phase;

    dna_multi_pattern_matcher_top #(.MAX_NODES(NODES)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_bus),
        .rsp(rsp_bus)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            rsp_bus.ready <= 1'b0;
        end
        else if (sb != null)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                sb.check('{rsp_bus.hit, rsp_bus.match_total, rsp_bus.text_done,
                           rsp_bus.status});
                accepted++;
            end
            phase++;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rsp_bus.ready <= 1'b0;
            end
            else if (!held_once && accepted >= 300)
            begin
                held_once = 1;
                hold_cnt = 400;
                rsp_bus.ready <= 1'b0;
            end
            else if (phase[6])
                rsp_bus.ready <= 1'b1;
            else
                rsp_bus.ready <= (phase % 7 != 3) && ($urandom_range(0, 3) != 0);
        end
    end

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 4))
            0: return CHAR_A;
            1: return CHAR_G;
            2: return CHAR_T;
            3: return 8'h43;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send(req_t r, logic [7:0] c, logic l);
        if (burst_left <= 0)
        begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 50);
        end
        req_bus.valid <= 1'b1;
        req_bus.req_type <= r;
        req_bus.char_code <= c;
        req_bus.last <= l;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        sb.note(r, c, l);
        burst_left--;
        sent++;
    endtask

    task automatic send_pattern(int len);
        for (int i = 0; i < len; i++)
            send(REQ_INSERT, pick_char(), i == len - 1);
    endtask

    task automatic send_text(int len, bit closed);
        for (int i = 0; i < len; i++)
            send(REQ_SCAN, pick_char(), closed && i == len - 1);
    endtask

    initial
    begin
        int pick;
        sb = new();
        sent = 0;
        accepted = 0;
        hold_cnt = 0;
        held_once = 0;
        phase = 0;
        burst_left = 0;
        rst_n <= 1'b0;
        req_bus.valid <= 1'b0;
        req_bus.req_type <= REQ_INSERT;
        req_bus.char_code <= '0;
        req_bus.last <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(REQ_INSERT, CHAR_A, 1'b0);
        send(REQ_INSERT, CHAR_G, 1'b1);
        send(REQ_INSERT, CHAR_G, 1'b0);
        send(REQ_INSERT, 8'hFF, 1'b1);
        send(REQ_SCAN, CHAR_A, 1'b0);
        send(REQ_SCAN, CHAR_G, 1'b0);
        send(REQ_SCAN, 8'h00, 1'b1);
        send(REQ_BUILD, 8'hAA, 1'b1);
        send(REQ_SCAN, CHAR_A, 1'b0);
        send(REQ_SCAN, CHAR_G, 1'b0);
        send(REQ_SCAN, 8'hFF, 1'b0);
        send(REQ_SCAN, CHAR_T, 1'b1);
        send(REQ_INSERT, CHAR_T, 1'b1);
        send(REQ_SCAN, CHAR_T, 1'b1);
        send(REQ_BUILD, 8'h55, 1'b0);
        send(REQ_BUILD, 8'h00, 1'b0);
        send(REQ_SCAN, CHAR_T, 1'b1);
        send(REQ_CLEAR, 8'hFF, 1'b1);
        send(REQ_SCAN, CHAR_A, 1'b1);
        for (int i = 0; i < 24; i++)
            send(REQ_INSERT, (i % 2) ? CHAR_G : CHAR_T, 1'b0);
        for (int i = 0; i < 45; i++)
            send(REQ_INSERT, (i % 2) ? CHAR_A : 8'h00, i % 5 == 4);
        send(REQ_BUILD, 8'h12, 1'b0);
        send_text(20, 1);
        send(REQ_CLEAR, 8'h00, 1'b0);

        while (sent < ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send(REQ_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (pick < 35)
                send_pattern($urandom_range(1, 5));
            else if (pick < 47)
                send(REQ_BUILD, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (pick < 93)
                send_text($urandom_range(1, 14), 1);
            else if (pick < 96)
                send_text($urandom_range(1, 4), 0);
            else
                send(req_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        end
        req_bus.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
